### src/slc_pkg.sv
`timescale 1ns / 1ps

package slc_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] MODE_SLASH = 3'd0;
  localparam logic [2:0] MODE_HASH  = 3'd1;
  localparam logic [2:0] MODE_DDASH = 3'd2;
  localparam logic [2:0] MODE_DASH  = 3'd3;
  localparam logic [2:0] MODE_PLAIN = 3'd4;

  typedef enum logic [5:0] {
    LS_CODE_START   = 6'b000001,
    LS_CODE_CTX     = 6'b000010,
    LS_SINGLE_START = 6'b000100,
    LS_SINGLE_CTX   = 6'b001000,
    LS_BLOCK_START  = 6'b010000,
    LS_BLOCK_CTX    = 6'b100000
  } line_state_t;

  typedef enum logic [1:0] {
    CLS_CODE          = 2'd0,
    CLS_COMMENT       = 2'd1,
    CLS_EMPTY         = 2'd2,
    CLS_EMPTY_COMMENT = 2'd3
  } line_class_t;

  typedef enum logic [1:0] {
    SKIP_NONE  = 2'd0,
    SKIP_SPACE = 2'd1,
    SKIP_AFTER_CR = 2'd2
  } skip_phase_t;

  typedef struct packed {
    line_class_t line_class;
    logic        adds_to_total;
    logic        run_end;
  } event_t;

  function automatic line_class_t class_of_state(input line_state_t ls);
    line_class_t c;
    case (ls)
      LS_SINGLE_START, LS_BLOCK_START: c = CLS_EMPTY_COMMENT;
      LS_SINGLE_CTX, LS_BLOCK_CTX:     c = CLS_COMMENT;
      LS_CODE_CTX:                     c = CLS_CODE;
      default:                         c = CLS_EMPTY;
    endcase
    return c;
  endfunction

endpackage

### src/source_line_classifier_top.sv
`timescale 1ns / 1ps

// Source line classifier.
// Input stream: one file byte per word on s_axis; s_axis_tlast marks the final
// byte of a file. Output stream: one line event per word on m_axis, with
// m_axis_tlast set on the last event caused by a given byte (a byte causes
// zero, one or two events).
// language_mode is loaded when language_mode_we is high; a write also restarts
// line tracking. Write it only while the block is idle.
// The events of an accepted byte are registered into the event queue and go out
// on m_axis once they reach its head. Throughput: one byte per cycle while the
// queue has room. Events sit in a four-word queue; a byte is taken while it
// holds two words or fewer, so a byte that yields two events fills two words
// and, if output keeps pace, does not hold up input. When the receiver stalls,
// the queue fills and s_axis_tready drops until room for two events is free again.
// Reset (rst, synchronous) empties the queue, sets slash comment mode and
// returns tracking to the start of a code line.
module source_line_classifier_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       language_mode_we,
  input  logic [2:0] language_mode,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [1:0] line_class, [2] adds_to_total, [7:3] zero
  output logic       m_axis_tlast    // run_end
);
  import slc_pkg::*;

  localparam int QDEPTH = 4;

  logic [2:0]  mode;
  line_state_t line_state, line_state_next;
  logic        pending_slash, pending_slash_next;
  logic        pending_star, pending_star_next;
  logic        pending_dash, pending_dash_next;
  logic        swallow_lf, swallow_lf_next;
  skip_phase_t skip_phase, skip_phase_next;

  event_t      q [QDEPTH];
  event_t      q_next [QDEPTH];
  logic [2:0]  count, count_next;

  line_class_t ev_cls [2];
  logic        ev_tot [2];
  logic [1:0]  ev_n;

  logic        in_fire;
  logic        out_fire;
  logic        plain;
  logic        consumed;
  logic [7:0]  b;

  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_fire      = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = (count <= 3'd2);
  assign m_axis_tvalid = (count != 3'd0);
  assign m_axis_tdata  = {5'd0, q[0].adds_to_total, q[0].line_class};
  assign m_axis_tlast  = q[0].run_end;
  assign plain         = (mode >= MODE_PLAIN);
  assign b             = s_axis_tdata;

  always_comb begin
    line_state_next    = line_state;
    pending_slash_next = pending_slash;
    pending_star_next  = pending_star;
    pending_dash_next  = pending_dash;
    swallow_lf_next    = swallow_lf;
    skip_phase_next    = skip_phase;
    consumed           = 1'b0;
    ev_n               = 2'd0;
    ev_cls[0]          = CLS_CODE;
    ev_cls[1]          = CLS_CODE;
    ev_tot[0]          = 1'b0;
    ev_tot[1]          = 1'b0;

    if (skip_phase == SKIP_SPACE) begin
      if (b == CH_SPACE) begin
        consumed = 1'b1;
      end else if (b == CH_CR) begin
        skip_phase_next = SKIP_AFTER_CR;
        consumed        = 1'b1;
      end else begin
        skip_phase_next = SKIP_NONE;
        consumed        = (b == CH_LF);
      end
    end else if (skip_phase == SKIP_AFTER_CR) begin
      skip_phase_next = SKIP_NONE;
      consumed        = (b == CH_LF);
    end else begin
      skip_phase_next = SKIP_NONE;
      if (swallow_lf) begin
        swallow_lf_next = 1'b0;
        consumed        = (b == CH_LF);
      end else if (pending_slash) begin
        pending_slash_next = 1'b0;
        if (b == CH_SLASH || b == CH_STAR) begin
          consumed = 1'b1;
          if (line_state == LS_CODE_CTX) begin
            ev_cls[ev_n[0]] = CLS_CODE;
            ev_tot[ev_n[0]] = 1'b0;
            ev_n            = ev_n + 2'd1;
          end
          if (line_state inside {LS_CODE_CTX, LS_CODE_START})
            line_state_next = (b == CH_SLASH) ? LS_SINGLE_START : LS_BLOCK_START;
        end
      end else if (pending_star) begin
        pending_star_next = 1'b0;
        if (b == CH_SLASH) begin
          consumed = 1'b1;
          if (line_state inside {LS_BLOCK_START, LS_BLOCK_CTX}) begin
            ev_cls[ev_n[0]] = (line_state == LS_BLOCK_START) ? CLS_EMPTY_COMMENT
                                                             : CLS_COMMENT;
            ev_tot[ev_n[0]] = 1'b1;
            ev_n            = ev_n + 2'd1;
            line_state_next = LS_CODE_START;
            skip_phase_next = SKIP_SPACE;
          end
        end
      end else if (pending_dash) begin
        pending_dash_next = 1'b0;
        if (b == CH_DASH) begin
          if (line_state_next == LS_CODE_CTX) begin
            ev_cls[ev_n[0]] = CLS_CODE;
            ev_tot[ev_n[0]] = 1'b0;
            ev_n            = ev_n + 2'd1;
            line_state_next = LS_SINGLE_START;
          end else if (line_state_next != LS_SINGLE_CTX) begin
            line_state_next = LS_SINGLE_START;
          end
        end
      end
    end

    if (!consumed) begin
      if (b == CH_CR || b == CH_LF) begin
        if (b == CH_CR)
          swallow_lf_next = 1'b1;
        if (ev_n < 2'd2) begin
          ev_cls[ev_n[0]] = plain ? CLS_CODE : class_of_state(line_state_next);
          ev_tot[ev_n[0]] = 1'b1;
          ev_n            = ev_n + 2'd1;
        end
        if (!plain) begin
          if (mode == MODE_SLASH && line_state_next == LS_BLOCK_CTX)
            line_state_next = LS_BLOCK_START;
          else if (mode != MODE_SLASH || line_state_next != LS_BLOCK_START)
            line_state_next = LS_CODE_START;
        end
      end else if (!plain) begin
        if (mode == MODE_SLASH && b == CH_SLASH) begin
          pending_slash_next = 1'b1;
        end else if (mode == MODE_SLASH && b == CH_STAR) begin
          pending_star_next = 1'b1;
        end else if (mode == MODE_DDASH && b == CH_DASH) begin
          pending_dash_next = 1'b1;
        end else if ((mode == MODE_HASH && (b == CH_HASH || b == CH_BANG)) ||
                     (mode == MODE_DASH && b == CH_DASH)) begin
          if (line_state_next == LS_CODE_CTX) begin
            if (ev_n < 2'd2) begin
              ev_cls[ev_n[0]] = CLS_CODE;
              ev_tot[ev_n[0]] = 1'b0;
              ev_n            = ev_n + 2'd1;
            end
            line_state_next = LS_SINGLE_START;
          end else if (line_state_next != LS_SINGLE_CTX) begin
            line_state_next = LS_SINGLE_START;
          end
        end else if (b != CH_SPACE) begin
          case (line_state_next)
            LS_CODE_START:   line_state_next = LS_CODE_CTX;
            LS_SINGLE_START: line_state_next = LS_SINGLE_CTX;
            LS_BLOCK_START:  line_state_next = LS_BLOCK_CTX;
            default:         line_state_next = line_state_next;
          endcase
        end
      end
    end

    if (s_axis_tlast) begin
      if (b != CH_LF && ev_n < 2'd2) begin
        ev_cls[ev_n[0]] = plain ? CLS_EMPTY : class_of_state(line_state_next);
        ev_tot[ev_n[0]] = 1'b0;
        ev_n            = ev_n + 2'd1;
      end
      line_state_next    = LS_CODE_START;
      pending_slash_next = 1'b0;
      pending_star_next  = 1'b0;
      pending_dash_next  = 1'b0;
      swallow_lf_next    = 1'b0;
      skip_phase_next    = SKIP_NONE;
    end
  end

  // event queue: head at entry 0, shifts down on pop
  always_comb begin
    q_next     = q;
    count_next = count;
    if (out_fire) begin
      for (int i = 0; i < QDEPTH - 1; i++)
        q_next[i] = q[i + 1];
      count_next = count - 3'd1;
    end
    if (in_fire && ev_n != 2'd0) begin
      q_next[count_next[1:0]] = '{ev_cls[0], ev_tot[0], ev_n == 2'd1};
      count_next              = count_next + 3'd1;
      if (ev_n == 2'd2) begin
        q_next[count_next[1:0]] = '{ev_cls[1], ev_tot[1], 1'b1};
        count_next              = count_next + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    if (rst) begin
      mode          <= MODE_SLASH;
      line_state    <= LS_CODE_START;
      pending_slash <= 1'b0;
      pending_star  <= 1'b0;
      pending_dash  <= 1'b0;
      swallow_lf    <= 1'b0;
      skip_phase    <= SKIP_NONE;
      count         <= 3'd0;
    end else begin
      count <= count_next;
      if (language_mode_we) begin
        mode          <= language_mode;
        line_state    <= LS_CODE_START;
        pending_slash <= 1'b0;
        pending_star  <= 1'b0;
        pending_dash  <= 1'b0;
        swallow_lf    <= 1'b0;
        skip_phase    <= SKIP_NONE;
      end else if (in_fire) begin
        line_state    <= line_state_next;
        pending_slash <= pending_slash_next;
        pending_star  <= pending_star_next;
        pending_dash  <= pending_dash_next;
        swallow_lf    <= swallow_lf_next;
        skip_phase    <= skip_phase_next;
      end
    end
  end

endmodule

### tb/sv/source_line_classifier_top_tb.sv
`timescale 1ns / 1ps

module source_line_classifier_top_tb;
  import slc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PREDICT = -1;
  localparam int PHASES = 12;
  localparam int PHASE_BYTES = 160;
  localparam logic [2:0] MODE_TOP = 3'd7;

  logic       clk;
  logic       rst = 1'b1;
  logic       language_mode_we = 1'b0;
  logic [2:0] language_mode = MODE_SLASH;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  source_line_classifier_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .language_mode_we (language_mode_we),
    .language_mode    (language_mode),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // line tracking copy
  logic [2:0]  trk_mode = MODE_SLASH;
  line_state_t trk_state = LS_CODE_START;
  logic        trk_slash = 1'b0;
  logic        trk_star = 1'b0;
  logic        trk_dash = 1'b0;
  logic        trk_swallow = 1'b0;
  skip_phase_t trk_skip = SKIP_NONE;
  event_t      step_events [2];
  int          step_count;

  event_t line_events [$];
  int     errors = 0;
  int     events_checked = 0;
  int     bytes_sent = 0;
  int     files_sent = 0;
  int     mode_writes = 0;
  int     holds_done = 0;
  int     burst_left = 0;
  int     idle_cycles = 0;
  bit     hold_req = 1'b0;

  function void restart_tracking();
    trk_state = LS_CODE_START;
    trk_slash = 1'b0;
    trk_star = 1'b0;
    trk_dash = 1'b0;
    trk_swallow = 1'b0;
    trk_skip = SKIP_NONE;
  endfunction

  function line_class_t state_class();
    case (trk_state)
      LS_SINGLE_START, LS_BLOCK_START: return CLS_EMPTY_COMMENT;
      LS_SINGLE_CTX, LS_BLOCK_CTX:     return CLS_COMMENT;
      LS_CODE_CTX:                     return CLS_CODE;
      default:                         return CLS_EMPTY;
    endcase
  endfunction

  function void add_event(line_class_t c, logic tot);
    if (step_count < 2) begin
      step_events[step_count] = '{line_class: c, adds_to_total: tot, run_end: 1'b0};
      step_count++;
    end
  endfunction

  function void comment_marker();
    if (trk_state == LS_CODE_CTX) begin
      add_event(CLS_CODE, 1'b0);
      trk_state = LS_SINGLE_START;
    end else if (trk_state != LS_SINGLE_CTX) begin
      trk_state = LS_SINGLE_START;
    end
  endfunction

  function void close_line();
    if (trk_mode >= MODE_PLAIN) begin
      add_event(CLS_CODE, 1'b1);
    end else begin
      add_event(state_class(), 1'b1);
      if (trk_mode == MODE_SLASH && trk_state == LS_BLOCK_CTX)
        trk_state = LS_BLOCK_START;
      else if (trk_mode != MODE_SLASH || trk_state != LS_BLOCK_START)
        trk_state = LS_CODE_START;
    end
  endfunction

  function void enter_text();
    case (trk_state)
      LS_CODE_START:   trk_state = LS_CODE_CTX;
      LS_SINGLE_START: trk_state = LS_SINGLE_CTX;
      LS_BLOCK_START:  trk_state = LS_BLOCK_CTX;
      default:         ;
    endcase
  endfunction

  function void plain_byte(logic [7:0] b);
    if (b == CH_CR || b == CH_LF) begin
      if (b == CH_CR) trk_swallow = 1'b1;
      close_line();
    end else if (trk_mode < MODE_PLAIN) begin
      if (trk_mode == MODE_SLASH && b == CH_SLASH) trk_slash = 1'b1;
      else if (trk_mode == MODE_SLASH && b == CH_STAR) trk_star = 1'b1;
      else if (trk_mode == MODE_HASH && (b == CH_HASH || b == CH_BANG)) comment_marker();
      else if (trk_mode == MODE_DDASH && b == CH_DASH) trk_dash = 1'b1;
      else if (trk_mode == MODE_DASH && b == CH_DASH) comment_marker();
      else if (b != CH_SPACE) enter_text();
    end
  endfunction

  function void classify_byte(logic [7:0] b, logic l);
    logic consumed;
    consumed = 1'b0;
    step_count = 0;
    if (trk_skip == SKIP_SPACE) begin
      if (b == CH_SPACE) begin
        consumed = 1'b1;
      end else if (b == CH_CR) begin
        trk_skip = SKIP_AFTER_CR;
        consumed = 1'b1;
      end else begin
        trk_skip = SKIP_NONE;
        consumed = (b == CH_LF);
      end
    end else if (trk_skip == SKIP_AFTER_CR) begin
      trk_skip = SKIP_NONE;
      consumed = (b == CH_LF);
    end else if (trk_swallow) begin
      trk_swallow = 1'b0;
      consumed = (b == CH_LF);
    end else if (trk_slash) begin
      trk_slash = 1'b0;
      if (b == CH_SLASH || b == CH_STAR) begin
        consumed = 1'b1;
        if (trk_state == LS_CODE_CTX) add_event(CLS_CODE, 1'b0);
        if (trk_state == LS_CODE_CTX || trk_state == LS_CODE_START)
          trk_state = (b == CH_SLASH) ? LS_SINGLE_START : LS_BLOCK_START;
      end
    end else if (trk_star) begin
      trk_star = 1'b0;
      if (b == CH_SLASH) begin
        consumed = 1'b1;
        if (trk_state == LS_BLOCK_START || trk_state == LS_BLOCK_CTX) begin
          add_event((trk_state == LS_BLOCK_START) ? CLS_EMPTY_COMMENT : CLS_COMMENT, 1'b1);
          trk_state = LS_CODE_START;
          trk_skip = SKIP_SPACE;
        end
      end
    end else if (trk_dash) begin
      trk_dash = 1'b0;
      if (b == CH_DASH) comment_marker();
    end
    if (!consumed) plain_byte(b);
    if (l) begin
      if (b != CH_LF) add_event((trk_mode >= MODE_PLAIN) ? CLS_EMPTY : state_class(), 1'b0);
      restart_tracking();
    end
    if (step_count > 0) step_events[step_count - 1].run_end = 1'b1;
  endfunction

  function logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return CH_SLASH;
      1:       return CH_STAR;
      2:       return CH_HASH;
      3:       return CH_BANG;
      4:       return CH_DASH;
      5, 6:    return CH_SPACE;
      7:       return CH_CR;
      8:       return CH_LF;
      9, 10:   return 8'h61 + 8'($urandom_range(0, 25));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(input logic [7:0] b, input logic l, input int typed_n,
                           input event_t t0, input event_t t1);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    burst_left--;
    bytes_sent++;
    if (l) files_sent++;
    classify_byte(b, l);
    if (typed_n == PREDICT) begin
      for (int k = 0; k < step_count; k++) line_events.push_back(step_events[k]);
    end else begin
      if (typed_n > 0) line_events.push_back(t0);
      if (typed_n > 1) line_events.push_back(t1);
    end
  endtask

  task automatic set_mode(input logic [2:0] m);
    s_axis_tvalid <= 1'b0;
    while (line_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    language_mode_we <= 1'b1;
    language_mode    <= m;
    @(posedge clk);
    language_mode_we <= 1'b0;
    trk_mode = m;
    restart_tracking();
    mode_writes++;
  endtask

  typedef struct {
    logic [2:0] mode;
    logic [7:0] b;
    logic       l;
    int         typed_n;
    event_t     e0;
    event_t     e1;
  } dir_row_t;

  localparam int DIR_ROWS = 28;

  // typed events: {line_class, adds_to_total, run_end}
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{MODE_SLASH, CH_LF,    1'b0, 1,       {CLS_EMPTY, 2'b11},         4'h0},
    '{MODE_SLASH, CH_SLASH, 1'b0, 0,       4'h0,                       4'h0},
    '{MODE_SLASH, CH_SLASH, 1'b0, 0,       4'h0,                       4'h0},
    '{MODE_SLASH, CH_CR,    1'b0, 1,       {CLS_EMPTY_COMMENT, 2'b11}, 4'h0},
    '{MODE_SLASH, CH_LF,    1'b0, 0,       4'h0,                       4'h0},
    '{MODE_SLASH, CH_SLASH, 1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_SLASH, CH_STAR,  1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_SLASH, CH_STAR,  1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_SLASH, CH_SLASH, 1'b0, 1,       {CLS_EMPTY_COMMENT, 2'b11}, 4'h0},
    '{MODE_SLASH, CH_SPACE, 1'b0, 0,       4'h0,                       4'h0},
    '{MODE_SLASH, CH_CR,    1'b0, 0,       4'h0,                       4'h0},
    '{MODE_SLASH, CH_LF,    1'b0, 0,       4'h0,                       4'h0},
    '{MODE_SLASH, CH_STAR,  1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_SLASH, 8'h71,    1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_SLASH, 8'hff,    1'b1, 1,       {CLS_CODE, 2'b01},          4'h0},
    '{MODE_HASH,  8'h00,    1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_HASH,  CH_HASH,  1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_HASH,  CH_BANG,  1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_HASH,  CH_LF,    1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_DDASH, CH_DASH,  1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_DDASH, 8'h61,    1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_DDASH, CH_DASH,  1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_DDASH, CH_DASH,  1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_DASH,  8'h61,    1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_DASH,  CH_DASH,  1'b0, PREDICT, 4'h0,                       4'h0},
    '{MODE_PLAIN, CH_CR,    1'b0, 1,       {CLS_CODE, 2'b11},          4'h0},
    '{MODE_PLAIN, 8'hff,    1'b1, 1,       {CLS_EMPTY, 2'b01},         4'h0},
    '{MODE_TOP,   CH_LF,    1'b1, 1,       {CLS_CODE, 2'b11},          4'h0}
  };

  // receiver: stall patterns, plus one long hold-off on request
  initial begin
    int style;
    int len;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      style = $urandom_range(0, 3);
      len = $urandom_range(8, 60);
      for (int i = 0; i < len; i++) begin
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= (i % 3 == 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    event_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (line_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = line_events.pop_front();
        events_checked++;
        if (m_axis_tdata[1:0] !== want.line_class) begin
          $display("%0t: line_class expected %0d actual %0d",
                   $time, want.line_class, m_axis_tdata[1:0]);
          errors++;
        end
        if (m_axis_tdata[2] !== want.adds_to_total) begin
          $display("%0t: adds_to_total expected %b actual %b",
                   $time, want.adds_to_total, m_axis_tdata[2]);
          errors++;
        end
        if (m_axis_tlast !== want.run_end) begin
          $display("%0t: run_end expected %b actual %b", $time, want.run_end, m_axis_tlast);
          errors++;
        end
        if (m_axis_tdata[7:3] !== 5'd0) begin
          $display("%0t: tdata pad expected 0 actual %h", $time, m_axis_tdata[7:3]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] tok [$];
    logic [2:0] m;
    int sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].mode != trk_mode) set_mode(dir_tab[r].mode);
      send_word(dir_tab[r].b, dir_tab[r].l, dir_tab[r].typed_n, dir_tab[r].e0, dir_tab[r].e1);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      m = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      set_mode(m);
      if (ph == 3) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        tok.delete();
        case ($urandom_range(0, 15))
          0: tok = '{CH_SLASH, CH_STAR};
          1: begin
            tok = '{CH_STAR, CH_SLASH};
            repeat ($urandom_range(0, 3)) tok.push_back(CH_SPACE);
            if ($urandom_range(0, 1)) tok.push_back(CH_CR);
            if ($urandom_range(0, 1)) tok.push_back(CH_LF);
          end
          2: tok = '{CH_SLASH, CH_SLASH};
          3: tok = '{CH_DASH, CH_DASH};
          4: tok = '{CH_CR, CH_LF};
          default: tok.push_back(pick_byte());
        endcase
        foreach (tok[k])
          send_word(tok[k], ($urandom_range(0, 59) == 0), PREDICT, '0, '0);
        sent += tok.size();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (line_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run: %0d bytes in %0d files, %0d mode writes, %0d long output hold-offs",
             bytes_sent, files_sent, mode_writes, holds_done);
    $display("run: %0d line events checked, %0d mismatches", events_checked, errors);
    if (errors == 0 && line_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
